// ----- rtl/tlvd_pkg.sv -----
package tlvd_pkg;

  localparam int TLVD_TABLE_ENTRIES = 16;
  localparam int TLVD_MAX_FIELDS    = 16;

  localparam logic [2:0] HDR_BYTES = 3'd5;

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] KIND_FIELD    = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd2;
  localparam logic [1:0] KIND_MISMATCH = 2'd3;

  typedef struct packed {
    logic        en;
    logic [3:0]  index;
    logic [15:0] id;
    logic [23:0] length;
    logic [4:0]  field_total;
    logic [31:0] formats;
    logic        enable;
  } tbl_write_t;

  // match part runs lowest slot first; read part ORs in the selected slot
  typedef struct packed {
    logic        found;
    logic        len_eq;
    logic [31:0] formats;
    logic [4:0]  field_total;
  } cell_link_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] message_id;
    logic [3:0]  slot;
    logic [3:0]  field_index;
    logic [1:0]  field_width;
    logic [63:0] field_value;
    logic        last;
    logic [23:0] length_seen;
  } result_t;

endpackage

// ----- rtl/tlvd_cell.sv -----
module tlvd_cell import tlvd_pkg::*; #(
  parameter int INDEX  = 0,
  parameter int SLOT_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  tbl_write_t        wr,
  input  logic [15:0]       key_id,
  input  logic [23:0]       key_len,
  input  logic [SLOT_W-1:0] rd_slot,
  input  cell_link_t        link_in,
  input  logic [SLOT_W-1:0] slot_in,
  output cell_link_t        link_out,
  output logic [SLOT_W-1:0] slot_out
);

  logic        valid;
  logic [15:0] id;
  logic [23:0] length;
  logic [31:0] formats;
  logic [4:0]  field_total;

  logic wr_hit;
  logic win;
  logic sel;

  assign wr_hit = wr.en && (32'(wr.index) == INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_hit) begin
      valid <= wr.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      id          <= wr.id;
      length      <= wr.length;
      formats     <= wr.formats;
      field_total <= wr.field_total;
    end
  end

  assign win = valid && (id == key_id) && !link_in.found;
  assign sel = (rd_slot == SLOT_W'(INDEX));

  always_comb begin
    link_out = link_in;
    if (win) begin
      link_out.found  = 1'b1;
      link_out.len_eq = (length == key_len);
    end
    if (sel) begin
      link_out.formats     = link_in.formats | formats;
      link_out.field_total = link_in.field_total | field_total;
    end
  end

  assign slot_out = win ? SLOT_W'(INDEX) : slot_in;

endmodule

// ----- rtl/tlvd_table.sv -----
module tlvd_table import tlvd_pkg::*; #(
  parameter int TABLE_ENTRIES = TLVD_TABLE_ENTRIES,
  parameter int SLOT_W        = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  tbl_write_t        wr,
  input  logic [15:0]       key_id,
  input  logic [23:0]       key_len,
  input  logic [SLOT_W-1:0] rd_slot,
  output logic              hit_found,
  output logic              hit_len_eq,
  output logic [SLOT_W-1:0] hit_slot,
  output logic [31:0]       rd_formats,
  output logic [4:0]        rd_field_total
);

  cell_link_t        link [TABLE_ENTRIES+1];
  logic [SLOT_W-1:0] slot_c [TABLE_ENTRIES+1];

  assign link[0]   = '0;
  assign slot_c[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    tlvd_cell #(
      .INDEX  (i),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (wr),
      .key_id   (key_id),
      .key_len  (key_len),
      .rd_slot  (rd_slot),
      .link_in  (link[i]),
      .slot_in  (slot_c[i]),
      .link_out (link[i+1]),
      .slot_out (slot_c[i+1])
    );
  end

  assign hit_found      = link[TABLE_ENTRIES].found;
  assign hit_len_eq     = link[TABLE_ENTRIES].len_eq;
  assign hit_slot       = slot_c[TABLE_ENTRIES];
  assign rd_formats     = link[TABLE_ENTRIES].formats;
  assign rd_field_total = link[TABLE_ENTRIES].field_total;

endmodule

// ----- rtl/tlvd_outbuf.sv -----
module tlvd_outbuf import tlvd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid;
  logic    load;

  assign space = !skid_valid;
  assign load  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      // skid drains first; new results only arrive while it is empty
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

endmodule

// ----- rtl/tlv_message_deframer_core.sv -----
// channel | handshake           | payload
// in      | in_valid / in_ready | action, data_byte, entry_index, entry_id, entry_length,
//         |                     | entry_field_total, entry_formats, entry_enable
// out     | out_valid/out_ready | kind, message_id, slot, field_index, field_width,
//         |                     | field_value, last, length_seen
//
// One transfer per cycle on the input while the skid is empty; results are registered.
// The id match is a priority chain through the row of table cells within that cycle.
// A two-entry output stage (register plus skid) keeps the input open while a result waits.
// Synchronous active-high reset clears the message state and all table valid bits.
module tlv_message_deframer_core import tlvd_pkg::*; #(
  parameter int TABLE_ENTRIES = TLVD_TABLE_ENTRIES,
  parameter int MAX_FIELDS    = TLVD_MAX_FIELDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  entry_index,
  input  logic [15:0] entry_id,
  input  logic [23:0] entry_length,
  input  logic [4:0]  entry_field_total,
  input  logic [31:0] entry_formats,
  input  logic        entry_enable,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] message_id,
  output logic [3:0]  slot,
  output logic [3:0]  field_index,
  output logic [1:0]  field_width,
  output logic [63:0] field_value,
  output logic        last,
  output logic [23:0] length_seen
);

  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [2:0]        hdr_count, hdr_count_next;
  logic [15:0]       hdr_id, hdr_id_next;
  logic [23:0]       hdr_len, hdr_len_next;
  logic [23:0]       remaining, remaining_next;
  logic [SLOT_W-1:0] active_slot, active_slot_next;
  logic              discard, discard_next;
  logic [4:0]        field_cursor, field_cursor_next;
  logic [2:0]        byte_cursor, byte_cursor_next;
  logic [63:0]       acc, acc_next;

  logic              fire;
  tbl_write_t        wr;
  logic [23:0]       key_len;
  logic              hit_found;
  logic              hit_len_eq;
  logic [SLOT_W-1:0] hit_slot;
  logic [31:0]       rd_formats;
  logic [4:0]        rd_field_total;
  logic [4:0]        total_lim;
  logic [1:0]        code;
  logic [3:0]        nbytes;
  logic [3:0]        byte_inc;
  logic [63:0]       acc_sh;
  logic [23:0]       rem_dec;
  logic              is_last;
  logic [SLOT_W+3:0] hit_slot_ext;
  logic [SLOT_W+3:0] active_slot_ext;
  logic              res_valid;
  result_t           res;
  result_t           out_data;
  logic              space;

  assign fire    = in_valid && in_ready;
  assign in_ready = space;
  assign key_len = {hdr_len[15:0], data_byte};

  always_comb begin
    wr             = '0;
    wr.en          = fire && (action == ACT_WRITE);
    wr.index       = entry_index;
    wr.id          = entry_id;
    wr.length      = entry_length;
    wr.field_total = entry_field_total;
    wr.formats     = entry_formats;
    wr.enable      = entry_enable;
  end

  tlvd_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SLOT_W        (SLOT_W)
  ) u_table (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .key_id         (hdr_id),
    .key_len        (key_len),
    .rd_slot        (active_slot),
    .hit_found      (hit_found),
    .hit_len_eq     (hit_len_eq),
    .hit_slot       (hit_slot),
    .rd_formats     (rd_formats),
    .rd_field_total (rd_field_total)
  );

  assign total_lim = (rd_field_total > 5'(MAX_FIELDS)) ? 5'(MAX_FIELDS) : rd_field_total;
  assign code      = rd_formats[{field_cursor[3:0], 1'b0} +: 2];
  assign nbytes    = 4'd1 << code;
  assign byte_inc  = {1'b0, byte_cursor} + 4'd1;
  assign acc_sh    = {acc[55:0], data_byte};
  assign rem_dec   = remaining - 24'd1;
  assign is_last   = (rem_dec == 24'd0);

  assign hit_slot_ext    = {4'b0, hit_slot};
  assign active_slot_ext = {4'b0, active_slot};

  always_comb begin
    hdr_count_next    = hdr_count;
    hdr_id_next       = hdr_id;
    hdr_len_next      = hdr_len;
    remaining_next    = remaining;
    active_slot_next  = active_slot;
    discard_next      = discard;
    field_cursor_next = field_cursor;
    byte_cursor_next  = byte_cursor;
    acc_next          = acc;
    res_valid         = 1'b0;
    res               = '0;
    res.message_id    = hdr_id;
    res.length_seen   = hdr_len;

    if (fire) begin
      unique case (action)
        ACT_BYTE: begin
          if (hdr_count < HDR_BYTES) begin
            hdr_count_next = hdr_count + 3'd1;
            if (hdr_count < 3'd2) begin
              hdr_id_next = {hdr_id[7:0], data_byte};
            end else begin
              hdr_len_next = key_len;
            end
            if (hdr_count == HDR_BYTES - 3'd1) begin
              active_slot_next  = hit_slot;
              remaining_next    = key_len;
              field_cursor_next = '0;
              byte_cursor_next  = '0;
              acc_next          = '0;
              res.length_seen   = key_len;
              res.slot          = hit_slot_ext[3:0];
              if (!hit_found || !hit_len_eq) begin
                // report once, then count the payload through
                discard_next = 1'b1;
                res_valid    = 1'b1;
                res.kind     = hit_found ? KIND_MISMATCH : KIND_UNKNOWN;
                if (key_len == 24'd0) begin
                  hdr_count_next = '0;
                  discard_next   = 1'b0;
                end
              end else begin
                discard_next = 1'b0;
                if (key_len == 24'd0) begin
                  hdr_count_next = '0;
                  res_valid      = 1'b1;
                  res.kind       = KIND_END;
                  res.last       = 1'b1;
                end
              end
            end
          end else begin
            remaining_next = rem_dec;
            res.slot       = active_slot_ext[3:0];
            if (is_last) begin
              hdr_count_next = '0;
            end
            if (discard) begin
              if (is_last) begin
                discard_next = 1'b0;
              end
            end else begin
              if (field_cursor < total_lim) begin
                if (byte_inc >= nbytes) begin
                  res_valid         = 1'b1;
                  res.kind          = KIND_FIELD;
                  res.field_index   = field_cursor[3:0];
                  res.field_width   = code;
                  res.field_value   = acc_sh;
                  res.last          = is_last;
                  field_cursor_next = field_cursor + 5'd1;
                  byte_cursor_next  = '0;
                  acc_next          = '0;
                end else begin
                  acc_next         = acc_sh;
                  byte_cursor_next = byte_inc[2:0];
                end
              end
              // final byte with no finished field: mark the end alone
              if (!res_valid && is_last) begin
                res_valid = 1'b1;
                res.kind  = KIND_END;
                res.last  = 1'b1;
              end
            end
          end
        end
        ACT_RESTART: begin
          hdr_count_next    = '0;
          hdr_id_next       = '0;
          hdr_len_next      = '0;
          remaining_next    = '0;
          active_slot_next  = '0;
          discard_next      = 1'b0;
          field_cursor_next = '0;
          byte_cursor_next  = '0;
          acc_next          = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_count    <= '0;
      hdr_id       <= '0;
      hdr_len      <= '0;
      remaining    <= '0;
      active_slot  <= '0;
      discard      <= 1'b0;
      field_cursor <= '0;
      byte_cursor  <= '0;
      acc          <= '0;
    end else begin
      hdr_count    <= hdr_count_next;
      hdr_id       <= hdr_id_next;
      hdr_len      <= hdr_len_next;
      remaining    <= remaining_next;
      active_slot  <= active_slot_next;
      discard      <= discard_next;
      field_cursor <= field_cursor_next;
      byte_cursor  <= byte_cursor_next;
      acc          <= acc_next;
    end
  end

  tlvd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign kind        = out_data.kind;
  assign message_id  = out_data.message_id;
  assign slot        = out_data.slot;
  assign field_index = out_data.field_index;
  assign field_width = out_data.field_width;
  assign field_value = out_data.field_value;
  assign last        = out_data.last;
  assign length_seen = out_data.length_seen;

endmodule

// ----- rtl/tlvd_checker.sv -----
module tlvd_checker import tlvd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] message_id,
  input logic [3:0]  slot,
  input logic [3:0]  field_index,
  input logic [1:0]  field_width,
  input logic [63:0] field_value,
  input logic        last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(kind) && $stable(message_id) && $stable(slot)
      && $stable(field_value) && $stable(last))
    else $error("output payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_UNKNOWN || kind == KIND_MISMATCH) |->
      !last && field_index == 4'd0 && field_width == 2'd0 && field_value == 64'd0)
    else $error("rejected header report carries field data");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_END |-> last && field_value == 64'd0
      && !(kind == KIND_UNKNOWN && slot != 4'd0))
    else $error("end marker without last");

endmodule

bind tlv_message_deframer_core tlvd_checker u_tlvd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .message_id  (message_id),
  .slot        (slot),
  .field_index (field_index),
  .field_width (field_width),
  .field_value (field_value),
  .last        (last)
);

// ----- tb/tlv_message_deframer_core_test.sv -----
`timescale 1ns / 1ps

module tlv_message_deframer_core_test;
  import tlvd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 445;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [3:0]  entry_index;
    logic [15:0] entry_id;
    logic [23:0] entry_length;
    logic [4:0]  entry_field_total;
    logic [31:0] entry_formats;
    logic        entry_enable;
  } stream_item_t;

  function automatic string show_result(result_t r);
    return $sformatf("kind %0d id %h slot %0d field %0d width %0d value %h last %0b len %0d",
                     r.kind, r.message_id, r.slot, r.field_index, r.field_width,
                     r.field_value, r.last, r.length_seen);
  endfunction

  // Tracks the deframer state and the message-type table, and queues the
  // result each accepted transfer should produce.
  class deframer_scoreboard;
    bit [2:0]    hdr_seen;
    bit [15:0]   cur_id;
    bit [23:0]   cur_len;
    bit [23:0]   payload_togo;
    bit [3:0]    cur_slot;
    bit          skipping;
    int unsigned field_no;
    int unsigned byte_no;
    bit [63:0]   acc;

    bit        slot_valid[TLVD_TABLE_ENTRIES];
    bit [15:0] slot_id[TLVD_TABLE_ENTRIES];
    bit [23:0] slot_len[TLVD_TABLE_ENTRIES];
    bit [31:0] slot_fmt[TLVD_TABLE_ENTRIES];
    bit [4:0]  slot_total[TLVD_TABLE_ENTRIES];

    result_t expected_q[$];
    int      mismatches;
    int      results_checked;

    function new();
      clear_message();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      mismatches = 0;
      results_checked = 0;
    endfunction

    function void clear_message();
      hdr_seen = '0;
      cur_id = '0;
      cur_len = '0;
      payload_togo = '0;
      cur_slot = '0;
      skipping = 1'b0;
      field_no = 0;
      byte_no = 0;
      acc = '0;
    endfunction

    function void queue_result(logic [1:0] k, bit [3:0] s, bit [3:0] fi, bit [1:0] fw,
                               bit [63:0] v, bit fin);
      result_t r;
      r.kind = k;
      r.message_id = cur_id;
      r.slot = s;
      r.field_index = fi;
      r.field_width = fw;
      r.field_value = v;
      r.last = fin;
      r.length_seen = cur_len;
      expected_q.push_back(r);
    endfunction

    function void take_header_byte(bit [7:0] b);
      bit found;
      if (hdr_seen < 2) cur_id = {cur_id[7:0], b};
      else cur_len = {cur_len[15:0], b};
      hdr_seen++;
      if (hdr_seen < HDR_BYTES) return;
      found = 1'b0;
      cur_slot = '0;
      for (int i = 0; i < TLVD_TABLE_ENTRIES; i++) begin
        if (!found && slot_valid[i] && slot_id[i] == cur_id) begin
          found = 1'b1;
          cur_slot = 4'(i);
        end
      end
      payload_togo = cur_len;
      field_no = 0;
      byte_no = 0;
      acc = '0;
      if (!found || slot_len[cur_slot] != cur_len) begin
        skipping = 1'b1;
        queue_result(found ? KIND_MISMATCH : KIND_UNKNOWN, found ? cur_slot : 4'd0,
                     4'd0, 2'd0, 64'd0, 1'b0);
        if (payload_togo == 0) begin
          hdr_seen = '0;
          skipping = 1'b0;
        end
      end else begin
        skipping = 1'b0;
        if (payload_togo == 0) begin
          hdr_seen = '0;
          queue_result(KIND_END, cur_slot, 4'd0, 2'd0, 64'd0, 1'b1);
        end
      end
    endfunction

    function void take_payload_byte(bit [7:0] b);
      int unsigned total;
      int unsigned code;
      bit fin;
      payload_togo--;
      fin = (payload_togo == 0);
      if (fin) hdr_seen = '0;
      if (skipping) begin
        if (fin) skipping = 1'b0;
        return;
      end
      total = slot_total[cur_slot];
      if (total > TLVD_MAX_FIELDS) total = TLVD_MAX_FIELDS;
      if (field_no < total) begin
        code = (slot_fmt[cur_slot] >> (2 * field_no)) & 3;
        acc = {acc[55:0], b};
        byte_no++;
        if (byte_no >= (1 << code)) begin
          queue_result(KIND_FIELD, cur_slot, field_no[3:0], code[1:0], acc, fin);
          field_no++;
          byte_no = 0;
          acc = '0;
          return;
        end
      end
      // final byte that closes no field still marks the message end
      if (fin) queue_result(KIND_END, cur_slot, 4'd0, 2'd0, 64'd0, 1'b1);
    endfunction

    function void note_item(stream_item_t it);
      case (it.action)
        ACT_BYTE: begin
          if (hdr_seen < HDR_BYTES) take_header_byte(it.data_byte);
          else take_payload_byte(it.data_byte);
        end
        ACT_WRITE: begin
          if (it.entry_index < TLVD_TABLE_ENTRIES) begin
            slot_id[it.entry_index] = it.entry_id;
            slot_len[it.entry_index] = it.entry_length;
            slot_total[it.entry_index] = it.entry_field_total;
            slot_fmt[it.entry_index] = it.entry_formats;
            slot_valid[it.entry_index] = it.entry_enable;
          end
        end
        ACT_RESTART: clear_message();
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", show_result(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.message_id !== want.message_id ||
          got.slot !== want.slot || got.field_index !== want.field_index ||
          got.field_width !== want.field_width || got.field_value !== want.field_value ||
          got.last !== want.last || got.length_seen !== want.length_seen) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $time);
          $display("  expected: %s", show_result(want));
          $display("  actual:   %s", show_result(got));
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit aligned();
      return hdr_seen == 0;
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_BYTE;
  logic [7:0]  data_byte = '0;
  logic [3:0]  entry_index = '0;
  logic [15:0] entry_id = '0;
  logic [23:0] entry_length = '0;
  logic [4:0]  entry_field_total = '0;
  logic [31:0] entry_formats = '0;
  logic        entry_enable = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [15:0] message_id;
  logic [3:0]  slot;
  logic [3:0]  field_index;
  logic [1:0]  field_width;
  logic [63:0] field_value;
  logic        last;
  logic [23:0] length_seen;

  tlv_message_deframer_core uut (.*);

  deframer_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ask_len = 0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int items_sent = 0;
  int writes_sent = 0;
  int restarts_sent = 0;
  int messages_sent = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[tlv_message_deframer_core] ERROR");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next ready value.
  always @(posedge clk) begin : result_side
    result_t got;
    if (out_valid && out_ready) begin
      got.kind = kind;
      got.message_id = message_id;
      got.slot = slot;
      got.field_index = field_index;
      got.field_width = field_width;
      got.field_value = field_value;
      got.last = last;
      got.length_seen = length_seen;
      sb.check_result(got);
    end
    if (!hold_taken && hold_ask_len > 0) begin
      hold_taken = 1'b1;
      hold_left = hold_ask_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic stream_item_t random_item();
    stream_item_t it;
    it.action = 2'($urandom_range(2));
    it.data_byte = 8'($urandom);
    it.entry_index = 4'($urandom);
    it.entry_id = 16'($urandom);
    it.entry_length = 24'($urandom);
    it.entry_field_total = 5'($urandom_range(16));
    it.entry_formats = $urandom;
    it.entry_enable = 1'($urandom);
    return it;
  endfunction

  task automatic push_item(stream_item_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    action <= it.action;
    data_byte <= it.data_byte;
    entry_index <= it.entry_index;
    entry_id <= it.entry_id;
    entry_length <= it.entry_length;
    entry_field_total <= it.entry_field_total;
    entry_formats <= it.entry_formats;
    entry_enable <= it.entry_enable;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    if (it.action == ACT_WRITE) writes_sent++;
    if (it.action == ACT_RESTART) restarts_sent++;
    items_sent++;
  endtask

  task automatic put_byte(bit [7:0] b);
    stream_item_t it;
    it = random_item();
    it.action = ACT_BYTE;
    it.data_byte = b;
    push_item(it);
  endtask

  task automatic put_entry(bit [3:0] idx, bit [15:0] id, bit [23:0] len, bit [4:0] total,
                           bit [31:0] fmt, bit en);
    stream_item_t it;
    it = random_item();
    it.action = ACT_WRITE;
    it.entry_index = idx;
    it.entry_id = id;
    it.entry_length = len;
    it.entry_field_total = total;
    it.entry_formats = fmt;
    it.entry_enable = en;
    push_item(it);
  endtask

  task automatic put_restart();
    stream_item_t it;
    it = random_item();
    it.action = ACT_RESTART;
    push_item(it);
  endtask

  task automatic put_unused();
    stream_item_t it;
    it = random_item();
    it.action = ACT_UNUSED;
    push_item(it);
  endtask

  task automatic put_header(bit [15:0] id, bit [23:0] len);
    put_byte(id[15:8]);
    put_byte(id[7:0]);
    put_byte(len[23:16]);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    messages_sent++;
  endtask

  function automatic bit [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bit [15:0] pick_id();
    case ($urandom_range(7))
      0: return 16'h0102;
      1: return 16'hFFFF;
      2: return 16'h0000;
      3: return 16'h8001;
      4: return 16'h00A5;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit [23:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 24'($urandom_range(24));
    if (r < 95) return 24'($urandom_range(60, 25));
    return 24'($urandom);
  endfunction

  // may_break: now and then cut the payload short or rewrite a table slot mid-message
  task automatic put_message(bit [15:0] id, bit [23:0] len, bit may_break);
    int r;
    put_header(id, len);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (may_break && r < 2) begin
        put_restart();
        return;
      end
      if (may_break && r < 4)
        put_entry(($urandom_range(1) != 0) ? sb.cur_slot : 4'($urandom), pick_id(),
                  pick_len(), 5'($urandom_range(16)), $urandom, $urandom_range(99) < 85);
      put_byte(pick_byte());
    end
  endtask

  task automatic random_unit();
    int r;
    int n;
    int pick;
    int live[$];
    bit [15:0] id;
    bit [23:0] len;
    r = $urandom_range(99);
    if (r < 12) begin
      put_entry(4'($urandom), pick_id(), pick_len(), 5'($urandom_range(16)), $urandom,
                $urandom_range(99) < 85);
    end else if (r < 15) begin
      put_restart();
    end else if (r < 17) begin
      put_unused();
    end else if (r < 21) begin
      // stray bytes knock the framing off; usually recover with a restart
      n = $urandom_range(3, 1);
      repeat (n) put_byte(8'($urandom));
      if ($urandom_range(99) < 70) put_restart();
    end else if (r < 24) begin
      if (!sb.aligned()) put_restart();
      put_header(pick_id(), 24'($urandom));
      n = $urandom_range(6);
      repeat (n) put_byte(pick_byte());
      put_restart();
    end else begin
      if (!sb.aligned()) put_restart();
      for (int i = 0; i < TLVD_TABLE_ENTRIES; i++)
        if (sb.slot_valid[i] && sb.slot_len[i] <= 60) live.push_back(i);
      if (live.size() > 0 && $urandom_range(99) < 80) begin
        pick = live[$urandom_range(live.size() - 1)];
        id = sb.slot_id[pick];
        len = sb.slot_len[pick];
        if ($urandom_range(9) == 0) len = len + 24'd1;
      end else begin
        id = pick_id();
        len = 24'($urandom_range(24));
      end
      put_message(id, len, 1'b1);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  int failures;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: zero-length accept, 1- and 2-byte fields with extreme bytes,
    // unknown id, length mismatch, unused action
    put_entry(4'd0, 16'h0102, 24'd3, 5'd2, 32'h0000_0004, 1'b1);
    put_entry(4'd15, 16'hFFFF, 24'd0, 5'd16, 32'hFFFF_FFFF, 1'b1);
    put_unused();
    put_message(16'hFFFF, 24'd0, 1'b0);
    put_header(16'h0102, 24'd3);
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_message(16'h0000, 24'd0, 1'b0);
    put_message(16'h0102, 24'd1, 1'b0);
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      n_target();
      wait_for_results();
    end

    // hold the result side off while one-byte fields pile up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    put_restart();
    put_entry(4'd0, 16'hBEEF, 24'd16, 5'd16, 32'h0000_0000, 1'b1);
    hold_ask_len = 150;
    put_message(16'hBEEF, 24'd16, 1'b0);
    put_message(16'hBEEF, 24'd16, 1'b0);
    wait_for_results();

    repeat (10) @(posedge clk);
    failures = sb.mismatches + sb.pending();
    $display("%0d transfers in (%0d table writes, %0d restarts, %0d headers), %0d results checked",
             items_sent, writes_sent, restarts_sent, messages_sent, sb.results_checked);
    $display("traffic ran with no idling, sender gaps, result-side stalls, both, and a long hold");
    if (failures == 0) begin
      $display("[tlv_message_deframer_core] OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("[tlv_message_deframer_core] ERROR");
    end
    $finish;
  end

  task automatic n_target();
    int goal;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) random_unit();
  endtask

endmodule
